FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: design/pfs_pkg.sv
package pfs_pkg;

  typedef struct packed {
    logic [15:0] mode_word;
    logic [7:0]  channel_number;
    logic [7:0]  output_switch;
    logic [31:0] frequency_word;
    logic [31:0] amplitude_scaled;
    logic [31:0] phase_scaled;
    logic [31:0] sweep_step;
    logic [31:0] sweep_step_time;
    logic [31:0] sweep_start;
    logic [31:0] sweep_stop;
  } item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
  } result_t;

  localparam int FRAME_LEN = 37;
  localparam int CRC_SPAN  = 34;          // bytes covered by the CRC
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int BODY_W    = CRC_SPAN * 8;

  localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(CRC_SPAN);
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(CRC_SPAN + 1);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  localparam logic [7:0]  HDR0      = 8'hAA;
  localparam logic [7:0]  HDR1      = 8'hA5;
  localparam logic [7:0]  TAIL      = 8'h55;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // One byte of CRC-16/MODBUS, LSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  // Byte idx of the CRC-covered part of the frame (idx below CRC_SPAN).
  function automatic logic [7:0] body_byte(input item_t it,
                                           input logic [IDX_W-1:0] idx);
    logic [BODY_W-1:0] body;
    logic [IDX_W-1:0]  rev;
    body = {HDR0, HDR1, it.mode_word, it.channel_number, it.output_switch,
            it.frequency_word, it.amplitude_scaled, it.phase_scaled,
            it.sweep_step, it.sweep_step_time, it.sweep_start, it.sweep_stop};
    rev  = IDX_W'(CRC_SPAN - 1) - idx;
    return body[{3'b000, rev} * 9'd8 +: 8];
  endfunction

endpackage

FILE: design/pfs_in_if.sv
interface pfs_in_if;
  logic          valid;
  logic          ready;
  pfs_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pfs_out_if.sv
interface pfs_out_if;
  logic             valid;
  logic             ready;
  pfs_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/param_frame_serializer_crc16_core.sv
// Frame serializer: each request on in_i carries one generator parameter set and
// produces a 37-byte frame on out_o, one byte per result, in transmit order:
// AA A5, mode (big-endian), channel, output switch, seven 32-bit big-endian
// words (frequency, amplitude, phase, sweep step, step time, start, stop), the
// CRC-16/MODBUS of bytes 0..33 high byte first, and the tail byte 55 flagged by
// last_of_frame. Rate: one frame byte per cycle while the receiver keeps out_o
// drained; the byte counter of the active frame walks each frame's bytes.
// A second request is held in a one-deep holding register while the current
// frame streams, so frames follow each other with no idle cycle. From an idle
// block an accepted request is registered as the active frame, and its first
// byte is then registered into the output register that drives out_o.
// The CRC is accumulated one byte per cycle as the body goes out, and holds while out_o stalls.
`include "assert_macros.svh"

module param_frame_serializer_crc16_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfs_in_if.sink            in_i,
  pfs_out_if.source         out_o
);

  // Active frame, being streamed
  logic                         act_valid_q, act_valid_d;
  pfs_pkg::item_t               act_q, act_d;
  logic [pfs_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [15:0]                  crc_q, crc_d;

  // Holding register for the next request
  logic                         pend_valid_q, pend_valid_d;
  pfs_pkg::item_t               pend_q, pend_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  pfs_pkg::result_t             out_q, out_d;

  logic                         in_fire;
  logic                         step;
  logic                         act_done;
  logic                         act_free;
  logic [7:0]                   cur_byte;
  logic [7:0]                   body_b;
  logic [15:0]                  crc_base;

  assign in_i.ready  = !pend_valid_q;
  assign in_fire     = in_i.valid && !pend_valid_q;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Advance one byte whenever the output register is free or being drained.
  assign step     = act_valid_q && (!out_valid_q || out_o.ready);
  assign act_done = step && (idx_q == pfs_pkg::IDX_LAST);
  assign act_free = !act_valid_q || act_done;

  assign body_b   = pfs_pkg::body_byte(act_q, idx_q);
  assign crc_base = (idx_q == '0) ? pfs_pkg::CRC_INIT : crc_q;

  always_comb begin
    if (idx_q < pfs_pkg::IDX_CRC_HI) begin
      cur_byte = body_b;
    end else if (idx_q == pfs_pkg::IDX_CRC_HI) begin
      cur_byte = crc_q[15:8];
    end else if (idx_q == pfs_pkg::IDX_CRC_LO) begin
      cur_byte = crc_q[7:0];
    end else begin
      cur_byte = pfs_pkg::TAIL;
    end
  end

  always_comb begin
    act_valid_d  = act_valid_q;
    act_d        = act_q;
    idx_d        = idx_q;
    crc_d        = crc_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (step) begin
      out_valid_d         = 1'b1;
      out_d.frame_byte    = cur_byte;
      out_d.last_of_frame = (idx_q == pfs_pkg::IDX_LAST);
      idx_d               = idx_q + 1'b1;
      if (idx_q < pfs_pkg::IDX_CRC_HI) begin
        crc_d = pfs_pkg::crc_update(crc_base, body_b);
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (act_free) begin
      // Start the next frame: held request first, else the incoming one; with neither, go idle.
      idx_d = '0;
      if (pend_valid_q) begin
        act_valid_d  = 1'b1;
        act_d        = pend_q;
        pend_valid_d = in_fire;
        if (in_fire) begin
          pend_d = in_i.data;
        end
      end else if (in_fire) begin
        act_valid_d = 1'b1;
        act_d       = in_i.data;
      end else begin
        act_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      pend_valid_d = 1'b1;
      pend_d       = in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      act_valid_q  <= act_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    pend_q <= pend_d;
    crc_q  <= crc_d;
    out_q  <= out_d;
  end

  `ASSERT_STD(a_last_is_tail, out_valid_q && out_q.last_of_frame |-> out_q.frame_byte == pfs_pkg::TAIL, "last byte is not the tail")
  `ASSERT_STD(a_idx_range, act_valid_q |-> idx_q <= pfs_pkg::IDX_LAST, "byte index out of range")
  `ASSERT_STD(a_pend_needs_act, pend_valid_q |-> act_valid_q, "held request with no active frame")
  `ASSERT_STD(a_first_is_hdr, step && idx_q == '0 |=> out_q.frame_byte == pfs_pkg::HDR0 && !out_q.last_of_frame, "frame does not open with header")

endmodule

FILE: tb/sv/tb_param_frame_serializer_crc16_core.sv
// Testbench for the parameter frame serializer. Each request on the input
// carries one generator parameter set; the block answers with 37 frame bytes.
// A local frame builder (header, big-endian fields, CRC-16/MODBUS, tail)
// queues the bytes each accepted request should produce, and a checker
// compares every accepted output byte against the head of that queue.
module tb_param_frame_serializer_crc16_core;

  // Frame layout
  localparam int         NUM_FRAME_BYTES = 37;
  localparam int         NUM_CRC_BYTES   = 34;  // bytes 0..33 feed the CRC
  localparam logic [7:0]  SYNC_A         = 8'hAA;
  localparam logic [7:0]  SYNC_B         = 8'hA5;
  localparam logic [7:0]  END_MARK       = 8'h55;
  localparam logic [15:0] MODBUS_SEED    = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY    = 16'hA001;  // reflected 0x8005

  // Allow plenty of slack after the last expected byte before declaring done.
  localparam int DRAIN_CYCLES   = 40;
  // Longest legit quiet stretch is the receiver hold-off (HOLDOFF_CYCLES).
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int MAX_REPORTS    = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfs_in_if  in_bus ();
  pfs_out_if out_bus ();

  param_frame_serializer_crc16_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #1 clk_i = ~clk_i;

  // Expected frame bytes, oldest first
  pfs_pkg::result_t expected_bytes_q[$];

  // Traffic shaping knobs: idle and stall odds in percent per cycle, and the hold-off still to run
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int holdoff_left   = 0;

  int fail_cnt     = 0;
  int report_cnt   = 0;
  int quiet_cycles = 0;

  pfs_pkg::result_t got_byte;
  pfs_pkg::result_t want_byte;

  // ---------------------------------------------------------------------------
  // Frame builder: assemble the 37 bytes a parameter set should produce and
  // append them to the expected queue. CRC is MODBUS: LSB-first shift,
  // reflected poly, no final xor, sent high byte first.
  // ---------------------------------------------------------------------------
  function automatic void build_frame(input pfs_pkg::item_t p);
    logic [7:0]  fb [NUM_FRAME_BYTES];
    logic [31:0] words [7];
    logic [15:0] crc;
    pfs_pkg::result_t r;
    words[0] = p.frequency_word;
    words[1] = p.amplitude_scaled;
    words[2] = p.phase_scaled;
    words[3] = p.sweep_step;
    words[4] = p.sweep_step_time;
    words[5] = p.sweep_start;
    words[6] = p.sweep_stop;
    fb[0] = SYNC_A;
    fb[1] = SYNC_B;
    fb[2] = p.mode_word[15:8];  // full high byte of the mode
    fb[3] = p.mode_word[7:0];
    fb[4] = p.channel_number;
    fb[5] = p.output_switch;
    for (int w = 0; w < 7; w++) begin
      for (int b = 0; b < 4; b++) begin
        fb[6 + 4 * w + b] = words[w][31 - 8 * b -: 8];
      end
    end
    crc = MODBUS_SEED;
    for (int i = 0; i < NUM_CRC_BYTES; i++) begin
      crc = crc ^ {8'h00, fb[i]};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ MODBUS_POLY) : (crc >> 1);
      end
    end
    fb[34] = crc[15:8];
    fb[35] = crc[7:0];
    fb[36] = END_MARK;
    for (int i = 0; i < NUM_FRAME_BYTES; i++) begin
      r.frame_byte    = fb[i];
      r.last_of_frame = (i == NUM_FRAME_BYTES - 1);
      expected_bytes_q.push_back(r);
    end
  endfunction

  // Field values biased toward the extremes, random otherwise
  function automatic logic [31:0] pick_field();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic pfs_pkg::item_t random_params();
    pfs_pkg::item_t p;
    p.mode_word        = 16'(pick_field());
    p.channel_number   = 8'(pick_field());
    // switch is mostly on/off in practice, but any byte is legal
    p.output_switch    = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1));
    p.frequency_word   = pick_field();
    p.amplitude_scaled = pick_field();
    p.phase_scaled     = pick_field();
    p.sweep_step       = pick_field();
    p.sweep_step_time  = pick_field();
    p.sweep_start      = pick_field();
    p.sweep_stop       = pick_field();
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Send one request. Inputs move on the falling edge; the accept is seen at
  // the rising edge. Valid is only ever written once per falling edge, so a
  // back-to-back request never sees a low/high pair in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_params(input pfs_pkg::item_t p);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.data  = p;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    build_frame(p);
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    fail_cnt++;
    if (report_cnt < MAX_REPORTS) begin
      report_cnt++;
      $display("mismatch %s: expected %0h got %0h", what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per cycle, plus a long hold-off counted down here
  // when a test arms holdoff_left.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      out_bus.ready = 1'b0;
      holdoff_left  = holdoff_left - 1;
    end else begin
      out_bus.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Output checker: every accepted byte against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got_byte = out_bus.data;
      if (expected_bytes_q.size() == 0) begin
        report_mismatch("unexpected byte", 0, int'(got_byte.frame_byte));
      end else begin
        want_byte = expected_bytes_q.pop_front();
        if (got_byte.frame_byte !== want_byte.frame_byte) begin
          report_mismatch("frame_byte", int'(want_byte.frame_byte),
                          int'(got_byte.frame_byte));
        end
        if (got_byte.last_of_frame !== want_byte.last_of_frame) begin
          report_mismatch("last_of_frame", int'(want_byte.last_of_frame),
                          int'(got_byte.last_of_frame));
        end
      end
    end
  end

  // Watchdog: too many cycles without any request or byte moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, byte-order checks, the mode high and low bytes, realistic values, walking ones,
  // and data that mimics the header/tail bytes (tail flag must stay on byte 36).
  task automatic test_directed_frames();
    pfs_pkg::item_t p;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_params('0);
    send_params('1);
    send_params({32{8'hAA}});
    send_params({32{8'h55}});
    send_params({16{16'hA5AA}});
    // mode high byte only, then low byte only
    p = '0;
    p.mode_word = 16'hFF00;
    send_params(p);
    p.mode_word = 16'h00FF;
    send_params(p);
    p = '0;
    p.mode_word      = 16'h1234;
    p.channel_number = 8'hFF;
    p.output_switch  = 8'h00;
    send_params(p);
    // typical settings: 3.3 amplitude and 180 degrees, already scaled
    p.mode_word        = 16'h0102;
    p.channel_number   = 8'd1;
    p.output_switch    = 8'd1;
    p.frequency_word   = 32'd1000;
    p.amplitude_scaled = 32'd3300;
    p.phase_scaled     = 32'd18000;
    p.sweep_step       = 32'd10;
    p.sweep_step_time  = 32'd1000;
    p.sweep_start      = 32'd100;
    p.sweep_stop       = 32'd10000;
    send_params(p);
    p.amplitude_scaled = 32'hFFFF_FFFF;
    p.phase_scaled     = 32'd36000;
    send_params(p);
    p = '1;
    p.frequency_word = 32'h0102_0304;  // word byte order
    p.sweep_stop     = 32'hDEAD_BEEF;
    send_params(p);
    // walking ones at the ends and the middle of the parameter set
    p = 256'(1);
    send_params(p);
    p = 256'(1) << 137;
    send_params(p);
    p = 256'(1) << 255;
    send_params(p);
  endtask

  task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                    input int count);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_params(random_params());
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the block fills its active frame and holding register, then must stall.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    holdoff_left   = HOLDOFF_CYCLES;
    for (int i = 0; i < 8; i++) begin
      send_params(random_params());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_frames();
    test_random_frames(0, 0, 24);    // no idling
    test_random_frames(51, 0, 24);   // sender gaps
    test_random_frames(0, 51, 24);   // receiver stalls
    test_random_frames(36, 36, 24);  // both
    test_output_backpressure();

    @(negedge clk_i);
    in_bus.valid   = 1'b0;
    sink_stall_pct = 0;

    // Drain; the watchdog covers a hang here
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_bytes_q.size() != 0) begin
      report_mismatch("bytes never sent", 0, expected_bytes_q.size());
    end

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
